// ===== rtl/ctli_pkg.sv =====
// Shared widths, codes and default sizes for the clamped table interpolator.
package ctli_pkg;

    // Field widths of the request and response transactions
    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int FLUID_W = 3;
    localparam int TEMP_W  = 32;
    localparam int VAL_W   = 48;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 7;

    // Default table geometry
    localparam int TABLE_LEN_DEF   = 64;
    localparam int FLUID_COUNT_DEF = 8;

    // Fraction precision of the interpolation weight
    localparam int FRAC_W = 16;

    // Reset value of the entries-in-use register
    localparam logic [CFG_W-1:0] ENTRIES_RST = 7'd64;

    // Opcodes
    localparam logic [OP_W-1:0] OP_WR_TEMP = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_VAL  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    // Clamp status codes
    localparam logic [STAT_W-1:0] ST_INTERIOR = 2'd0;
    localparam logic [STAT_W-1:0] ST_CLAMP_LO = 2'd1;
    localparam logic [STAT_W-1:0] ST_CLAMP_HI = 2'd2;

endpackage

// ===== rtl/ctli_req_if.sv =====
// Request channel: table writes and interpolation queries.
interface ctli_req_if;
    logic                                valid;
    logic                                ready;
    logic [ctli_pkg::OP_W-1:0]           opcode;
    logic [ctli_pkg::IDX_W-1:0]          entry_index;
    logic [ctli_pkg::FLUID_W-1:0]        fluid_select;
    logic [ctli_pkg::TEMP_W-1:0]         temp_entry;
    logic signed [ctli_pkg::VAL_W-1:0]   value_entry;
    logic [ctli_pkg::TEMP_W-1:0]         query_temp;

    modport source (
        output valid, opcode, entry_index, fluid_select, temp_entry, value_entry, query_temp,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, fluid_select, temp_entry, value_entry, query_temp,
        output ready
    );
endinterface

// ===== rtl/ctli_rsp_if.sv =====
// Response channel: interpolated value and clamp status.
interface ctli_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctli_pkg::VAL_W-1:0]   result_value;
    logic [ctli_pkg::STAT_W-1:0]         clamp_status;

    modport source (
        output valid, result_value, clamp_status,
        input  ready
    );
    modport sink (
        input  valid, result_value, clamp_status,
        output ready
    );
endinterface

// ===== rtl/clamped_table_linear_interpolator_unit.sv =====
// Clamped table linear interpolator: breakpoint and value tables, search and interpolation.
//
// Write transactions (temperature breakpoint or per-fluid value) are written when accepted.
// A query first checks the low and high ends, otherwise binary-searches the breakpoint
// table with one registered memory read per step (ceil(log2(entries in use - 1))
// steps, 6 for 64 entries), then a 16-step restoring division forms the fraction
// and a 16-step shift-add multiply applies it, all on one shared 66-bit add/subtract
// unit. Queries are handled one at a time; a finished result waits in an output
// register while the next transaction is taken. Both tables hold no reset value:
// query only entries that have been written.
module clamped_table_linear_interpolator_unit #(
    parameter int TABLE_LEN   = ctli_pkg::TABLE_LEN_DEF,
    parameter int FLUID_COUNT = ctli_pkg::FLUID_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ctli_pkg::CFG_W-1:0]  cfg_wdata,
    ctli_req_if.sink                    req,
    ctli_rsp_if.source                  rsp
);

    localparam int AW    = $clog2(TABLE_LEN);
    localparam int VDEP  = TABLE_LEN * FLUID_COUNT;
    localparam int VAW   = (VDEP > 1) ? $clog2(VDEP) : 1;
    localparam int CW    = $clog2(TABLE_LEN + 1);
    localparam int TW    = ctli_pkg::TEMP_W;
    localparam int VW    = ctli_pkg::VAL_W;
    localparam int FW    = ctli_pkg::FRAC_W;
    localparam int DW    = VW + 1;             // difference of two values
    localparam int ACW   = DW + FW + 1;        // signed product accumulator
    localparam int CNTW  = $clog2(FW);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CMP_LO = 4'd1;
    localparam logic [3:0] S_CMP_HI = 4'd2;
    localparam logic [3:0] S_SEARCH = 4'd3;
    localparam logic [3:0] S_SCMP   = 4'd4;
    localparam logic [3:0] S_LD0    = 4'd5;
    localparam logic [3:0] S_LD1    = 4'd6;
    localparam logic [3:0] S_DELTA  = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_MUL    = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // Table memories
    logic [TW-1:0]        t_mem [TABLE_LEN];
    logic signed [VW-1:0] v_mem [VDEP];
    logic [TW-1:0]        t_q;
    logic signed [VW-1:0] v_q;
    logic                 t_we;
    logic                 v_we;
    logic [AW-1:0]        t_waddr;
    logic [VAW-1:0]       v_waddr;
    logic [AW-1:0]        t_raddr;
    logic [VAW-1:0]       v_raddr;

    // Control and datapath registers
    logic [3:0]              state_reg, state_next;
    logic [ctli_pkg::CFG_W-1:0] cfg_reg;
    logic [TW-1:0]           temp_reg, temp_next;
    logic [VAW-1:0]          base_reg, base_next;
    logic [AW-1:0]           lo_reg, lo_next;
    logic [AW-1:0]           hi_reg, hi_next;
    logic [AW-1:0]           mid_reg, mid_next;
    logic [TW-1:0]           t0_reg, t0_next;
    logic [TW-1:0]           rem_reg, rem_next;
    logic [TW-1:0]           div_reg, div_next;
    logic signed [VW-1:0]    f0_reg, f0_next;
    logic signed [VW-1:0]    f1_reg, f1_next;
    logic signed [DW-1:0]    delta_reg, delta_next;
    logic [FW-1:0]           q_reg, q_next;
    logic signed [ACW-1:0]   acc_reg, acc_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic signed [VW-1:0]    res_reg, res_next;
    logic [ctli_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic                    out_val_reg, out_val_next;
    logic signed [VW-1:0]    out_res_reg, out_res_next;
    logic [ctli_pkg::STAT_W-1:0] out_stat_reg, out_stat_next;

    // Shared add/subtract unit
    logic [ACW-1:0] add_a, add_b, add_sum;
    logic           add_sub;
    logic           add_neg;

    // Misc combinational
    logic [CW-1:0]  n_used;
    logic [AW-1:0]  last_idx;
    logic [AW:0]    span;
    logic [AW-1:0]  mid_idx;
    logic           req_acc;
    logic           idx_ok;
    logic           fluid_ok;
    logic [VAW-1:0] in_base;
    logic [TW:0]    div_shift;

    // Clamp the entries-in-use register to between two and the table size
    always_comb
    begin
        if (cfg_reg < 7'd2)
            n_used = CW'(2);
        else if (32'(cfg_reg) > TABLE_LEN)
            n_used = CW'(TABLE_LEN);
        else
            n_used = CW'(cfg_reg);
        last_idx = AW'(n_used - CW'(1));
    end

    assign span    = {1'b0, hi_reg} - {1'b0, lo_reg};
    assign mid_idx = AW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);

    // Request decode
    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;
    assign idx_ok    = (32'(req.entry_index) < TABLE_LEN);
    assign fluid_ok  = (32'(req.fluid_select) < FLUID_COUNT);
    assign in_base   = VAW'(32'(req.fluid_select) * TABLE_LEN);

    // Table writes
    assign t_we    = req_acc && (req.opcode == ctli_pkg::OP_WR_TEMP) && idx_ok;
    assign v_we    = req_acc && (req.opcode == ctli_pkg::OP_WR_VAL) && idx_ok && fluid_ok;
    assign t_waddr = AW'(req.entry_index);
    assign v_waddr = VAW'(in_base + VAW'(req.entry_index));

    always_ff @(posedge clk)
    begin
        if (t_we)
            t_mem[t_waddr] <= req.temp_entry;
        t_q <= t_mem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            v_mem[v_waddr] <= req.value_entry;
        v_q <= v_mem[v_raddr];
    end

    // Shared adder
    assign add_sum   = add_a + (add_sub ? ~add_b : add_b) + ACW'(add_sub);
    assign add_neg   = add_sum[ACW-1];
    assign div_shift = {rem_reg, 1'b0};

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        temp_next     = temp_reg;
        base_next     = base_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        t0_next       = t0_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        f0_next       = f0_reg;
        f1_next       = f1_reg;
        delta_next    = delta_reg;
        q_next        = q_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        stat_next     = stat_reg;
        out_val_next  = out_val_reg && !rsp.ready;
        out_res_next  = out_res_reg;
        out_stat_next = out_stat_reg;
        t_raddr       = '0;
        v_raddr       = base_reg;
        add_a         = '0;
        add_b         = '0;
        add_sub       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                v_raddr = in_base;
                if (req_acc && (req.opcode == ctli_pkg::OP_QUERY))
                begin
                    temp_next = req.query_temp;
                    base_next = in_base;
                    if (fluid_ok)
                        state_next = S_CMP_LO;
                    else
                    begin
                        res_next   = '0;
                        stat_next  = ctli_pkg::ST_INTERIOR;
                        state_next = S_DONE;
                    end
                end
            end

            // Low end: first breakpoint and value are in the read registers
            S_CMP_LO:
            begin
                add_a   = ACW'(temp_reg);
                add_b   = ACW'(t_q);
                add_sub = 1'b1;
                t_raddr = last_idx;
                v_raddr = VAW'(base_reg + VAW'(last_idx));
                if (add_neg || (add_sum[TW-1:0] == '0))
                begin
                    res_next   = v_q;
                    stat_next  = ctli_pkg::ST_CLAMP_LO;
                    state_next = S_DONE;
                end
                else
                    state_next = S_CMP_HI;
            end

            // High end: last breakpoint in use
            S_CMP_HI:
            begin
                add_a   = ACW'(temp_reg);
                add_b   = ACW'(t_q);
                add_sub = 1'b1;
                if (!add_neg)
                begin
                    res_next   = v_q;
                    stat_next  = ctli_pkg::ST_CLAMP_HI;
                    state_next = S_DONE;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = last_idx;
                    state_next = S_SEARCH;
                end
            end

            // Binary search: issue midpoint read, or fetch the bin's low end
            S_SEARCH:
            begin
                if (span > (AW+1)'(1))
                begin
                    t_raddr    = mid_idx;
                    mid_next   = mid_idx;
                    state_next = S_SCMP;
                end
                else
                begin
                    t_raddr    = lo_reg;
                    v_raddr    = VAW'(base_reg + VAW'(lo_reg));
                    state_next = S_LD0;
                end
            end

            S_SCMP:
            begin
                add_a   = ACW'(temp_reg);
                add_b   = ACW'(t_q);
                add_sub = 1'b1;
                if (!add_neg)
                    lo_next = mid_reg;
                else
                    hi_next = mid_reg;
                state_next = S_SEARCH;
            end

            // t0, f0 arrive; numerator T - t0; fetch the bin's high end
            S_LD0:
            begin
                add_a      = ACW'(temp_reg);
                add_b      = ACW'(t_q);
                add_sub    = 1'b1;
                rem_next   = add_sum[TW-1:0];
                t0_next    = t_q;
                f0_next    = v_q;
                t_raddr    = hi_reg;
                v_raddr    = VAW'(base_reg + VAW'(hi_reg));
                state_next = S_LD1;
            end

            // Divisor t1 - t0
            S_LD1:
            begin
                add_a      = ACW'(t_q);
                add_b      = ACW'(t0_reg);
                add_sub    = 1'b1;
                div_next   = add_sum[TW-1:0];
                f1_next    = v_q;
                state_next = S_DELTA;
            end

            // Value difference f1 - f0
            S_DELTA:
            begin
                add_a      = ACW'(f1_reg);
                add_b      = ACW'(f0_reg);
                add_sub    = 1'b1;
                delta_next = DW'(add_sum);
                q_next     = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end

            // Restoring division, one quotient bit a cycle
            S_DIV:
            begin
                add_a   = ACW'(div_shift);
                add_b   = ACW'(div_reg);
                add_sub = 1'b1;
                if (add_neg)
                begin
                    rem_next = div_shift[TW-1:0];
                    q_next   = {q_reg[FW-2:0], 1'b0};
                end
                else
                begin
                    rem_next = add_sum[TW-1:0];
                    q_next   = {q_reg[FW-2:0], 1'b1};
                end
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(FW - 1))
                begin
                    acc_next   = '0;
                    state_next = S_MUL;
                end
            end

            // Shift-add multiply of delta by the fraction, MSB first
            S_MUL:
            begin
                add_a    = ACW'(acc_reg <<< 1);
                add_b    = q_reg[FW-1] ? ACW'(delta_reg) : '0;
                acc_next = add_sum;
                q_next   = {q_reg[FW-2:0], 1'b0};
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(FW - 1))
                    state_next = S_FIN;
            end

            // f0 plus the floored scaled difference
            S_FIN:
            begin
                add_a      = ACW'(f0_reg);
                add_b      = ACW'(acc_reg >>> FW);
                res_next   = add_sum[VW-1:0];
                stat_next  = ctli_pkg::ST_INTERIOR;
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (!out_val_reg || rsp.ready)
                begin
                    out_val_next  = 1'b1;
                    out_res_next  = res_reg;
                    out_stat_next = stat_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cfg_reg     <= ctli_pkg::ENTRIES_RST;
            out_val_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            out_val_reg <= out_val_next;
            cnt_reg     <= cnt_next;
            if (cfg_we)
                cfg_reg <= cfg_wdata;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        temp_reg     <= temp_next;
        base_reg     <= base_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        t0_reg       <= t0_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        f0_reg       <= f0_next;
        f1_reg       <= f1_next;
        delta_reg    <= delta_next;
        q_reg        <= q_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        stat_reg     <= stat_next;
        out_res_reg  <= out_res_next;
        out_stat_reg <= out_stat_next;
    end

    // Response channel
    assign rsp.valid        = out_val_reg;
    assign rsp.result_value = out_res_reg;
    assign rsp.clamp_status = out_stat_reg;

endmodule

// ===== tb/tb.sv =====
// Testbench for the clamped table linear interpolator: directed table, random traffic, checks.
`timescale 1ns / 1ps

module tb;
    import ctli_pkg::*;

    localparam int TABLE_LEN       = TABLE_LEN_DEF;
    localparam int FLUIDS          = FLUID_COUNT_DEF;
    localparam int QUIET_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 500;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DRAIN_CYCLES    = 60;
    localparam int PHASES          = 9;

    // Opcode 3 is not decoded by the block
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [IDX_W-1:0]   entry_index;
        logic [FLUID_W-1:0] fluid_select;
        logic [TEMP_W-1:0]  temp_entry;
        logic [VAL_W-1:0]   value_entry;
        logic [TEMP_W-1:0]  query_temp;
    } req_item_t;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [STAT_W-1:0] status;
    } rsp_item_t;

    typedef struct {
        req_item_t item;
        bit        typed;
        rsp_item_t want;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    ctli_req_if req_if ();
    ctli_rsp_if rsp_if ();

    clamped_table_linear_interpolator_unit #(
        .TABLE_LEN   (TABLE_LEN),
        .FLUID_COUNT (FLUIDS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // Shadow copy of the tables and the entries-in-use register
    logic [TEMP_W-1:0] bp_temp [TABLE_LEN];
    logic [VAL_W-1:0]  fluid_rows [FLUIDS][TABLE_LEN];
    logic [CFG_W-1:0]  entries_cfg = ENTRIES_RST;

    rsp_item_t pending_results [$];
    dir_row_t  directed_rows [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int tx_idle_pct    = 6;
    int rx_idle_pct;
    int hold_req;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int used_entries();
        int n;
        n = entries_cfg;
        if (n < 2)
            n = 2;
        if (n > TABLE_LEN)
            n = TABLE_LEN;
        return n;
    endfunction

    // Clamp at the ends, else binary search for the bin and interpolate
    function automatic rsp_item_t interp_value(input logic [TEMP_W-1:0] t,
                                               input logic [FLUID_W-1:0] f);
        rsp_item_t res;
        int n, lo, hi, mid;
        longint f0, f1, delta, y;
        longint unsigned num, den, frac, mag, prod;
        n = used_entries();
        res.status = ST_INTERIOR;
        if (t <= bp_temp[0])
        begin
            res.value  = fluid_rows[f][0];
            res.status = ST_CLAMP_LO;
        end
        else if (t >= bp_temp[n-1])
        begin
            res.value  = fluid_rows[f][n-1];
            res.status = ST_CLAMP_HI;
        end
        else
        begin
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1)
            begin
                mid = lo + (hi - lo) / 2;
                if (t >= bp_temp[mid])
                    lo = mid;
                else
                    hi = mid;
            end
            num   = t - bp_temp[lo];
            den   = bp_temp[hi] - bp_temp[lo];
            frac  = (num << FRAC_W) / den;
            f0    = $signed(fluid_rows[f][lo]);
            f1    = $signed(fluid_rows[f][hi]);
            delta = f1 - f0;
            // floor of the scaled step: round the magnitude up when going down
            if (delta < 0)
            begin
                mag  = -delta;
                prod = mag * frac;
                y    = f0 - longint'((prod + 64'hFFFF) >> FRAC_W);
            end
            else
            begin
                mag  = delta;
                prod = mag * frac;
                y    = f0 + longint'(prod >> FRAC_W);
            end
            res.value = y[VAL_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        longint s;
        case ($urandom_range(0, 9))
            0:       return 48'h7FFF_FFFF_FFFF;
            1:       return 48'h8000_0000_0000;
            2:       return '0;
            3:       return '1;
            4, 5:
            begin
                s = longint'($urandom_range(0, 4000)) - 2000;
                return s[VAL_W-1:0];
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Transaction with every payload field random
    function automatic req_item_t noise_item(input logic [OP_W-1:0] op);
        req_item_t it;
        it.opcode       = op;
        it.entry_index  = $urandom_range(0, TABLE_LEN - 1);
        it.fluid_select = $urandom_range(0, FLUIDS - 1);
        it.temp_entry   = $urandom;
        it.value_entry  = rand_value();
        it.query_temp   = $urandom;
        return it;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input int idx, input int fl,
                           input logic [TEMP_W-1:0] te, input logic [VAL_W-1:0] ve,
                           input logic [TEMP_W-1:0] qt, input bit typed,
                           input logic [VAL_W-1:0] wv, input logic [STAT_W-1:0] ws);
        dir_row_t row;
        row.item.opcode       = op;
        row.item.entry_index  = idx[IDX_W-1:0];
        row.item.fluid_select = fl[FLUID_W-1:0];
        row.item.temp_entry   = te;
        row.item.value_entry  = ve;
        row.item.query_temp   = qt;
        row.typed             = typed;
        row.want.value        = wv;
        row.want.status       = ws;
        directed_rows.push_back(row);
    endtask

    // Offer one transaction, wait for acceptance, then update the shadow state
    task automatic send_item(input req_item_t it, input bit typed, input rsp_item_t want);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.opcode       <= it.opcode;
        req_if.entry_index  <= it.entry_index;
        req_if.fluid_select <= it.fluid_select;
        req_if.temp_entry   <= it.temp_entry;
        req_if.value_entry  <= it.value_entry;
        req_if.query_temp   <= it.query_temp;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        case (it.opcode)
            OP_WR_TEMP: bp_temp[it.entry_index] = it.temp_entry;
            OP_WR_VAL:  fluid_rows[it.fluid_select][it.entry_index] = it.value_entry;
            OP_QUERY:
            begin
                if (typed)
                    pending_results.push_back(want);
                else
                    pending_results.push_back(interp_value(it.query_temp, it.fluid_select));
            end
            default: ;
        endcase
    endtask

    // Register write once the block has drained
    task automatic set_entries(input int unsigned v);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v[CFG_W-1:0];
        @(posedge clk);
        cfg_we      <= 1'b0;
        entries_cfg = v[CFG_W-1:0];
    endtask

    // Rewrite breakpoints 0..n-1 in ascending order with tiny, medium or wide spacing
    task automatic rebuild_temps(input int n);
        longint unsigned step_max, cur;
        req_item_t it;
        case ($urandom_range(0, 2))
            0:       step_max = 3;
            1:       step_max = 65536;
            default: step_max = 64'hFFFF_FFFF / (n - 1);
        endcase
        cur = $urandom_range(0, 32'(64'hFFFF_FFFF - (n - 1) * step_max));
        for (int i = 0; i < n; i++)
        begin
            it             = noise_item(OP_WR_TEMP);
            it.entry_index = i;
            it.temp_entry  = cur[TEMP_W-1:0];
            send_item(it, 1'b0, '0);
            cur += $urandom_range(1, 32'(step_max));
        end
    endtask

    // Response side: random back-pressure, plus a long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Compare each response transaction with the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        rsp_item_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("response with no query outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.result_value !== want.value)
                    report_mismatch($sformatf("result_value %0d, want %0d",
                                              rsp_if.result_value, $signed(want.value)));
                if (rsp_if.clamp_status !== want.status)
                    report_mismatch($sformatf("clamp_status %0d, want %0d",
                                              rsp_if.clamp_status, want.status));
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** clamped_table_linear_interpolator_unit: FAILED **");
        $finish;
    end

    // Stimulus
    initial
    begin
        int n, p, k, r, j, sel;
        int unsigned cfg_list [PHASES];
        req_item_t it;

        req_if.valid        <= 1'b0;
        req_if.opcode       <= OP_WR_TEMP;
        req_if.entry_index  <= '0;
        req_if.fluid_select <= '0;
        req_if.temp_entry   <= '0;
        req_if.value_entry  <= '0;
        req_if.query_temp   <= '0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        rst_n               <= 1'b0;
        rx_idle_pct         <= 86;
        hold_req            <= 0;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            bp_temp[i] = '0;
            for (int f = 0; f < FLUIDS; f++)
                fluid_rows[f][i] = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero entries in use behaves as two
        set_entries(0);

        // Directed: two breakpoints 100.0 and 200.0, fluid 0 rising, fluid 7 full swing
        add_row(OP_WR_TEMP, 0, 0, 32'h6400, '0, '0, 0, '0, ST_INTERIOR);
        add_row(OP_WR_TEMP, 1, 0, 32'hC800, '0, '0, 0, '0, ST_INTERIOR);
        add_row(OP_WR_VAL, 0, 0, '0, 48'd1000, '0, 0, '0, ST_INTERIOR);
        add_row(OP_WR_VAL, 1, 0, '0, 48'd2000, '0, 0, '0, ST_INTERIOR);
        add_row(OP_WR_VAL, 0, 7, '0, 48'h7FFF_FFFF_FFFF, '0, 0, '0, ST_INTERIOR);
        add_row(OP_WR_VAL, 1, 7, '0, 48'h8000_0000_0000, '0, 0, '0, ST_INTERIOR);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'h0, 1, 48'd1000, ST_CLAMP_LO);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'h6400, 1, 48'd1000, ST_CLAMP_LO);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'h7D00, 1, 48'd1250, ST_INTERIOR);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'hC7FF, 0, '0, ST_INTERIOR);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'hC800, 1, 48'd2000, ST_CLAMP_HI);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'hFFFF_FFFF, 1, 48'd2000, ST_CLAMP_HI);
        add_row(OP_QUERY, 0, 7, '0, '0, 32'h0, 1, 48'h7FFF_FFFF_FFFF, ST_CLAMP_LO);
        add_row(OP_QUERY, 0, 7, '0, '0, 32'hFFFF_FFFF, 1, 48'h8000_0000_0000, ST_CLAMP_HI);
        add_row(OP_QUERY, 0, 7, '0, '0, 32'h6401, 0, '0, ST_INTERIOR);
        add_row(OP_QUERY, 0, 7, '0, '0, 32'h9600, 0, '0, ST_INTERIOR);
        add_row(OP_UNUSED, 63, 7, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, 0, '0, ST_INTERIOR);
        // falling row, then a bin only two LSBs wide
        add_row(OP_WR_VAL, 1, 0, '0, 48'd0, '0, 0, '0, ST_INTERIOR);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'h9600, 0, '0, ST_INTERIOR);
        add_row(OP_WR_TEMP, 1, 0, 32'h6402, '0, '0, 0, '0, ST_INTERIOR);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'h6401, 0, '0, ST_INTERIOR);
        // full temperature span, top index written
        add_row(OP_WR_TEMP, 63, 0, 32'hFFFF_FFFF, '0, '0, 0, '0, ST_INTERIOR);
        add_row(OP_WR_TEMP, 0, 0, 32'h0, '0, '0, 0, '0, ST_INTERIOR);
        add_row(OP_WR_TEMP, 1, 0, 32'hFFFF_FFFF, '0, '0, 0, '0, ST_INTERIOR);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'h0, 1, 48'd1000, ST_CLAMP_LO);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'h8000_0000, 0, '0, ST_INTERIOR);
        add_row(OP_QUERY, 0, 0, '0, '0, 32'hFFFF_FFFF, 1, 48'd0, ST_CLAMP_HI);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // Fill every breakpoint and every value so no query reads an unwritten entry
        rebuild_temps(TABLE_LEN);
        for (int f = 0; f < FLUIDS; f++)
            for (int i = 0; i < TABLE_LEN; i++)
            begin
                it              = noise_item(OP_WR_VAL);
                it.entry_index  = i;
                it.fluid_select = f;
                send_item(it, 1'b0, '0);
            end

        // Random phases, each at its own entries-in-use setting
        cfg_list = '{64, 1, 127, 5, 2, 17, 65, 64, 0};
        cfg_list[PHASES-1] = $urandom_range(3, 63);
        for (p = 0; p < PHASES; p++)
        begin
            set_entries(cfg_list[p]);
            if (p < 3)
            begin
                tx_idle_pct = 6;
                rx_idle_pct <= 86;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 86;
                rx_idle_pct <= 6;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            // long response hold-off while queries keep coming
            if (p == 6)
                hold_req <= hold_req + 1;
            n = used_entries();
            rebuild_temps(n);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    rebuild_temps(n);
                else if (r < 55)
                begin
                    it  = noise_item(OP_QUERY);
                    sel = $urandom_range(0, 9);
                    case (sel)
                        0: it.query_temp = 32'hFFFF_FFFF;
                        1: it.query_temp = ($urandom_range(0, 1) != 0) ? '0 : bp_temp[0];
                        2: it.query_temp = bp_temp[n-1];
                        3, 4, 5:
                        begin
                            j = $urandom_range(0, n - 1);
                            it.query_temp = bp_temp[j] + 32'($urandom_range(0, 2)) - 32'd1;
                        end
                        9: ;
                        default: it.query_temp = $urandom_range(bp_temp[0], bp_temp[n-1]);
                    endcase
                    send_item(it, 1'b0, '0);
                end
                else if (r < 78)
                    send_item(noise_item(OP_WR_VAL), 1'b0, '0);
                else if (r < 94)
                begin
                    // mostly small nudges, which may break the ascending order
                    it = noise_item(OP_WR_TEMP);
                    if ($urandom_range(0, 4) != 0)
                        it.temp_entry = bp_temp[it.entry_index] + 32'($urandom_range(0, 6))
                                        - 32'd3;
                    send_item(it, 1'b0, '0);
                end
                else
                    send_item(noise_item(OP_UNUSED), 1'b0, '0);
            end
        end

        // Drain
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("queries left without a response");

        if (mismatch_count == 0)
            $display("** clamped_table_linear_interpolator_unit: PASSED **");
        else
            $display("** clamped_table_linear_interpolator_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ctli_pkg.sv
rtl/ctli_req_if.sv
rtl/ctli_rsp_if.sv
rtl/clamped_table_linear_interpolator_unit.sv
tb/tb.sv
